[rtl/core/multi_reader_packet_framer_defines.svh]
// ----------------------------------------------------------------------------
// Multi-reader packet framer - assertion macros
// Concurrent check wrappers; they compile to nothing in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef MULTI_READER_PACKET_FRAMER_DEFINES_SVH
`define MULTI_READER_PACKET_FRAMER_DEFINES_SVH

`ifndef SYNTHESIS
// check under reset qualification
`define MRPF_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("mrpf: assertion failed");
// check that also holds while reset is applied
`define MRPF_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("mrpf: assertion failed");
`else
`define MRPF_ASSERT(lbl, clk, rstn, prop)
`define MRPF_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

[rtl/core/mrpf_pkg.sv]
// ----------------------------------------------------------------------------
// Multi-reader packet framer - package
// Shared types and fixed constants of the framer.
// ----------------------------------------------------------------------------
package mrpf_pkg;

  // readers that have configuration registers
  localparam int CFG_READERS = 2;

  // expiry limits are held in microseconds
  localparam int LIMIT_W = 26;
  localparam int US_PER_MS = 1000;
  localparam int CONTROL_TIMEOUT_MS = 100;
  localparam logic [LIMIT_W-1:0] CONTROL_LIMIT_US =
    LIMIT_W'(CONTROL_TIMEOUT_MS * US_PER_MS);

  localparam logic [10:0] CONTROL_OVERHEAD = 11'd18;
  localparam int HEADER_CHECK_COUNT = 6;

  typedef enum logic [1:0] {
    ST_NONE     = 2'd0,
    ST_INVALID  = 2'd1,
    ST_COMPLETE = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0]  start_byte;
    logic [10:0] size;
    logic        is_control;
  } lane_cfg_t;

  localparam lane_cfg_t DEFAULT_LANE_CFG = '{
    start_byte: 8'd0,
    size:       11'd2,
    is_control: 1'b0
  };

  typedef struct packed {
    logic advance;  // request moves to the result register this cycle
    logic clear;    // overflow: drop the partial packet
    logic take;     // byte continues this reader's packet
    logic open;     // byte opens a packet on this reader
  } lane_cmd_t;

  typedef struct packed {
    logic active;   // packet in progress before expiry
    logic busy;     // packet in progress after expiry
    logic match;    // byte equals the start byte
  } lane_stat_t;

  typedef struct packed {
    status_t     status;
    logic [9:0]  pos;
  } lane_res_t;

endpackage

[rtl/core/mrpf_cfg.sv]
// ----------------------------------------------------------------------------
// Multi-reader packet framer - configuration registers
// APB-style register file; also keeps the data expiry limit in microseconds.
// ----------------------------------------------------------------------------
module mrpf_cfg (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        psel,
  input  logic                                        penable,
  input  logic                                        pwrite,
  input  logic [4:0]                                  paddr,
  input  logic [31:0]                                 pwdata,
  output logic [31:0]                                 prdata,
  output logic                                        pready,
  output mrpf_pkg::lane_cfg_t [mrpf_pkg::CFG_READERS-1:0] lane_cfg,
  output logic [mrpf_pkg::LIMIT_W-1:0]                data_limit,
  output logic [10:0]                                 ctrl_max
);

  localparam logic [2:0] REG_R0_START = 3'd0;
  localparam logic [2:0] REG_R0_SIZE  = 3'd1;
  localparam logic [2:0] REG_R0_CTRL  = 3'd2;
  localparam logic [2:0] REG_R1_START = 3'd3;
  localparam logic [2:0] REG_R1_SIZE  = 3'd4;
  localparam logic [2:0] REG_R1_CTRL  = 3'd5;
  localparam logic [2:0] REG_TIMEOUT  = 3'd6;
  localparam logic [2:0] REG_CTRL_MAX = 3'd7;

  mrpf_pkg::lane_cfg_t [1:0]          lane_r;
  logic [15:0]                        timeout_r;
  logic [mrpf_pkg::LIMIT_W-1:0]       limit_r;
  logic [10:0]                        ctrl_max_r;
  logic                               wr_en;
  logic [2:0]                         idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_r[0]  <= mrpf_pkg::DEFAULT_LANE_CFG;
      lane_r[1]  <= '{start_byte: 8'd0, size: 11'd2, is_control: 1'b1};
      timeout_r  <= 16'd100;
      limit_r    <= mrpf_pkg::LIMIT_W'(100 * mrpf_pkg::US_PER_MS);
      ctrl_max_r <= 11'd1024;
    end else if (wr_en) begin
      case (idx)
        REG_R0_START: lane_r[0].start_byte <= pwdata[7:0];
        REG_R0_SIZE:  lane_r[0].size       <= pwdata[10:0];
        REG_R0_CTRL:  lane_r[0].is_control <= pwdata[0];
        REG_R1_START: lane_r[1].start_byte <= pwdata[7:0];
        REG_R1_SIZE:  lane_r[1].size       <= pwdata[10:0];
        REG_R1_CTRL:  lane_r[1].is_control <= pwdata[0];
        REG_TIMEOUT: begin
          timeout_r <= pwdata[15:0];
          limit_r   <= mrpf_pkg::LIMIT_W'(pwdata[15:0]) *
                       mrpf_pkg::LIMIT_W'(mrpf_pkg::US_PER_MS);
        end
        REG_CTRL_MAX: ctrl_max_r <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_R0_START: prdata = {24'd0, lane_r[0].start_byte};
      REG_R0_SIZE:  prdata = {21'd0, lane_r[0].size};
      REG_R0_CTRL:  prdata = {31'd0, lane_r[0].is_control};
      REG_R1_START: prdata = {24'd0, lane_r[1].start_byte};
      REG_R1_SIZE:  prdata = {21'd0, lane_r[1].size};
      REG_R1_CTRL:  prdata = {31'd0, lane_r[1].is_control};
      REG_TIMEOUT:  prdata = {16'd0, timeout_r};
      REG_CTRL_MAX: prdata = {21'd0, ctrl_max_r};
      default:      prdata = '0;
    endcase
  end

  assign lane_cfg   = lane_r;
  assign data_limit = limit_r;
  assign ctrl_max   = ctrl_max_r;

endmodule

[rtl/core/mrpf_lane.sv]
// ----------------------------------------------------------------------------
// Multi-reader packet framer - reader lane
// Per-reader packet state: expiry, byte count, control header check, size.
// ----------------------------------------------------------------------------
module mrpf_lane #(
  parameter int MAX_PACKET_BYTES = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mrpf_pkg::lane_cfg_t           cfg,
  input  logic [mrpf_pkg::LIMIT_W-1:0]  data_limit,
  input  logic [10:0]                   ctrl_max,
  input  logic [63:0]                   now,
  input  logic [7:0]                    data_byte,
  input  mrpf_pkg::lane_cmd_t           cmd,
  output mrpf_pkg::lane_stat_t          stat,
  output mrpf_pkg::lane_res_t           res
);

  localparam int FILL_W = $clog2(MAX_PACKET_BYTES + 1);
  localparam int CMP_W  = (FILL_W > 11) ? FILL_W : 11;
  localparam int POS_W  = (FILL_W > 10) ? FILL_W : 10;
  localparam logic [CMP_W-1:0] MAX_LIM = CMP_W'(MAX_PACKET_BYTES);

  logic [FILL_W-1:0]            fill_r, fill_nxt;
  logic [63:0]                  last_time_r, last_time_nxt;
  logic [10:0]                  exp_r, exp_nxt;
  logic [7:0]                   hdr1_r, hdr1_nxt;
  logic [7:0]                   hdr3_r, hdr3_nxt;
  logic [7:0]                   hdr4_r, hdr4_nxt;

  logic [63:0]                  diff;
  logic [mrpf_pkg::LIMIT_W-1:0] limit;
  logic                         expired;
  logic [FILL_W-1:0]            fill_e;
  logic [FILL_W-1:0]            fill_inc;
  logic                         is_hdr;
  logic [15:0]                  payload;
  logic [10:0]                  max_pay;
  logic                         bad_hdr;
  logic [10:0]                  exp_hdr;
  logic [10:0]                  exp_use;
  logic [CMP_W-1:0]             lim;
  logic                         done;
  logic [POS_W-1:0]             pos_ext;

  // expiry: elapsed time read as signed, stale once it reaches the limit
  assign diff    = now - last_time_r;
  assign limit   = cfg.is_control ? mrpf_pkg::CONTROL_LIMIT_US : data_limit;
  assign expired = (fill_r != '0) && !diff[63] &&
                   (diff >= {{(64 - mrpf_pkg::LIMIT_W){1'b0}}, limit});
  assign fill_e  = expired ? '0 : fill_r;

  assign stat.active = (fill_r != '0);
  assign stat.busy   = (fill_e != '0);
  assign stat.match  = (data_byte == cfg.start_byte);

  assign fill_inc = fill_e + FILL_W'(1);

  // header check on the sixth byte of a control packet
  assign is_hdr  = cfg.is_control &&
                   (fill_inc == FILL_W'(mrpf_pkg::HEADER_CHECK_COUNT));
  assign payload = {data_byte, hdr4_r};
  assign max_pay = (ctrl_max >= mrpf_pkg::CONTROL_OVERHEAD) ?
                   (ctrl_max - mrpf_pkg::CONTROL_OVERHEAD) : 11'd0;
  assign bad_hdr = (payload > {5'd0, max_pay}) || (hdr1_r != 8'd1) ||
                   (hdr3_r != 8'd0);
  assign exp_hdr = payload[10:0] + mrpf_pkg::CONTROL_OVERHEAD;
  assign exp_use = is_hdr ? exp_hdr : exp_r;

  // clamp the size to the storage limit
  assign lim  = (CMP_W'(exp_use) > MAX_LIM) ? MAX_LIM : CMP_W'(exp_use);
  assign done = (CMP_W'(fill_inc) >= lim);

  assign pos_ext = POS_W'(fill_e);

  always_comb begin
    fill_nxt      = fill_r;
    last_time_nxt = last_time_r;
    exp_nxt       = exp_r;
    hdr1_nxt      = hdr1_r;
    hdr3_nxt      = hdr3_r;
    hdr4_nxt      = hdr4_r;
    res.status    = mrpf_pkg::ST_NONE;
    res.pos       = 10'd0;
    if (cmd.take) begin
      res.pos = pos_ext[9:0];
      if (is_hdr && bad_hdr) begin
        res.status = mrpf_pkg::ST_INVALID;
      end else if (done) begin
        res.status = mrpf_pkg::ST_COMPLETE;
      end
    end
    if (cmd.advance) begin
      fill_nxt = fill_e;
      if (cmd.clear) begin
        fill_nxt = '0;
      end else if (cmd.take) begin
        last_time_nxt = now;
        case (fill_e)
          FILL_W'(1): hdr1_nxt = data_byte;
          FILL_W'(3): hdr3_nxt = data_byte;
          FILL_W'(4): hdr4_nxt = data_byte;
          default: ;
        endcase
        if (is_hdr && !bad_hdr) begin
          exp_nxt = exp_hdr;
        end
        if ((is_hdr && bad_hdr) || done) begin
          fill_nxt = '0;
        end else begin
          fill_nxt = fill_inc;
        end
      end else if (cmd.open) begin
        fill_nxt      = FILL_W'(1);
        last_time_nxt = now;
        exp_nxt       = cfg.is_control ? ctrl_max : cfg.size;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  // packet payload state is only read while a packet is in progress
  always_ff @(posedge clk) begin
    last_time_r <= last_time_nxt;
    exp_r       <= exp_nxt;
    hdr1_r      <= hdr1_nxt;
    hdr3_r      <= hdr3_nxt;
    hdr4_r      <= hdr4_nxt;
  end

endmodule

[rtl/core/multi_reader_packet_framer.sv]
// ----------------------------------------------------------------------------
// Multi-reader packet framer - top level
// Frames timestamped bytes into packets for several readers.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one request per byte, overflow event or time tick. in_tuser holds
//           the kind, in_tdata the byte and the microsecond timestamp.
//   out_* : exactly one result per request: status in out_tuser, and the
//           reader, taken flag and byte offset in out_tdata.
//   cfg_* : register port; write only while no request is in flight.
// Requests pass the input register, then the result register that drives
// out_tvalid; the reader lanes update their state as it loads. Throughput is
// one request per cycle while out_tready is high; the lane expiry compare and
// header check sit in the single stage between input and result registers.
// When the receiver holds out_tready low the result register holds and the
// input register still takes one more request; in_tready drops after that.
// Synchronous reset clears all packets in progress, both valid flags and
// loads the register reset values; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "multi_reader_packet_framer_defines.svh"

module multi_reader_packet_framer #(
  parameter int NUM_READERS      = 2,
  parameter int MAX_PACKET_BYTES = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // [7:0] data_byte, [71:8] time_us
  input  logic [1:0]  in_tuser,   // [1:0] kind
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [0] reader_id, [1] byte_taken,
                                  // [11:2] byte_position, [15:12] zero
  output logic [1:0]  out_tuser,  // [1:0] status
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int ID_W = (NUM_READERS > 1) ? $clog2(NUM_READERS) : 1;

  localparam logic [1:0] KIND_DATA     = 2'd0;
  localparam logic [1:0] KIND_OVERFLOW = 2'd1;

  mrpf_pkg::lane_cfg_t [mrpf_pkg::CFG_READERS-1:0] reg_cfg;
  mrpf_pkg::lane_cfg_t [NUM_READERS-1:0]           lcfg;
  mrpf_pkg::lane_cmd_t [NUM_READERS-1:0]           lcmd;
  mrpf_pkg::lane_stat_t [NUM_READERS-1:0]          lstat;
  mrpf_pkg::lane_res_t [NUM_READERS-1:0]           lres;
  logic [mrpf_pkg::LIMIT_W-1:0]                    data_limit;
  logic [10:0]                                     ctrl_max;

  logic              in_v_r;
  logic [1:0]        in_kind_r;
  logic [7:0]        in_byte_r;
  logic [63:0]       in_time_r;

  logic              advance;
  logic              is_data;
  logic [NUM_READERS-1:0] take_vec;
  logic [NUM_READERS-1:0] open_vec;
  logic [NUM_READERS-1:0] active_vec;
  logic              found;
  logic [ID_W-1:0]   sel_id;
  logic [1:0]        lane_status;
  logic [9:0]        lane_pos;

  logic              out_v_r;
  logic [1:0]        status_r, status_nxt;
  logic              rid_r, rid_nxt;
  logic              taken_r, taken_nxt;
  logic [9:0]        pos_r, pos_nxt;

  mrpf_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (cfg_psel),
    .penable    (cfg_penable),
    .pwrite     (cfg_pwrite),
    .paddr      (cfg_paddr),
    .pwdata     (cfg_pwdata),
    .prdata     (cfg_prdata),
    .pready     (cfg_pready),
    .lane_cfg   (reg_cfg),
    .data_limit (data_limit),
    .ctrl_max   (ctrl_max)
  );

  // ---- input register ------------------------------------------------------
  assign advance   = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_kind_r <= in_tuser;
      in_byte_r <= in_tdata[7:0];
      in_time_r <= in_tdata[71:8];
    end
  end

  // ---- reader selection ----------------------------------------------------
  assign is_data = (in_kind_r == KIND_DATA);

  always_comb begin
    take_vec = '0;
    open_vec = '0;
    found    = 1'b0;
    sel_id   = '0;
    // a partial packet has first claim on the byte
    for (int i = 0; i < NUM_READERS; i++) begin
      if (!found && lstat[i].busy) begin
        take_vec[i] = 1'b1;
        found       = 1'b1;
        sel_id      = ID_W'(i);
      end
    end
    for (int i = 0; i < NUM_READERS; i++) begin
      if (!found && lstat[i].match) begin
        open_vec[i] = 1'b1;
        found       = 1'b1;
        sel_id      = ID_W'(i);
      end
    end
    if (!is_data) begin
      take_vec = '0;
      open_vec = '0;
      found    = 1'b0;
    end
  end

  genvar g;
  generate
    for (g = 0; g < NUM_READERS; g++) begin : g_lane
      if (g < mrpf_pkg::CFG_READERS) begin : g_reg
        assign lcfg[g] = reg_cfg[g];
      end else begin : g_fixed
        assign lcfg[g] = mrpf_pkg::DEFAULT_LANE_CFG;
      end

      assign lcmd[g].advance = advance;
      assign lcmd[g].clear   = (in_kind_r == KIND_OVERFLOW);
      assign lcmd[g].take    = take_vec[g];
      assign lcmd[g].open    = open_vec[g];
      assign active_vec[g]   = lstat[g].active;

      mrpf_lane #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
      ) u_lane (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (lcfg[g]),
        .data_limit (data_limit),
        .ctrl_max   (ctrl_max),
        .now        (in_time_r),
        .data_byte  (in_byte_r),
        .cmd        (lcmd[g]),
        .stat       (lstat[g]),
        .res        (lres[g])
      );
    end
  endgenerate

  // lanes not taking the byte report zero, so OR them together
  always_comb begin
    lane_status = 2'd0;
    lane_pos    = 10'd0;
    for (int i = 0; i < NUM_READERS; i++) begin
      lane_status = lane_status | lres[i].status;
      lane_pos    = lane_pos | lres[i].pos;
    end
  end

  always_comb begin
    status_nxt = mrpf_pkg::ST_NONE;
    rid_nxt    = 1'b0;
    taken_nxt  = 1'b0;
    pos_nxt    = 10'd0;
    if (in_kind_r == KIND_OVERFLOW) begin
      status_nxt = mrpf_pkg::ST_INVALID;
    end else if (found) begin
      status_nxt = lane_status;
      rid_nxt    = sel_id[0];
      taken_nxt  = 1'b1;
      pos_nxt    = lane_pos;
    end
  end

  // ---- result register -----------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      status_r <= status_nxt;
      rid_r    <= rid_nxt;
      taken_r  <= taken_nxt;
      pos_r    <= pos_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = status_r;
  assign out_tdata  = {4'd0, pos_r, taken_r, rid_r};

  // ---- checks --------------------------------------------------------------
  `MRPF_ASSERT(a_one_reader, clk, rst_n, $onehot0(take_vec | open_vec))
  `MRPF_ASSERT(a_complete_taken, clk, rst_n,
    (out_v_r && (status_r == mrpf_pkg::ST_COMPLETE)) |-> taken_r)
  `MRPF_ASSERT(a_overflow_clears, clk, rst_n,
    (advance && (in_kind_r == KIND_OVERFLOW)) |=> (active_vec == '0))
  `MRPF_ASSERT(a_untaken_quiet, clk, rst_n,
    (out_v_r && !taken_r) |-> ((pos_r == 10'd0) && !rid_r &&
                               (status_r != mrpf_pkg::ST_COMPLETE)))
  `MRPF_ASSERT_ALWAYS(a_reset_empty, clk,
    $past(!rst_n) |-> (!in_v_r && !out_v_r && (active_vec == '0)))

endmodule
